// ===== hw/rtl/itoa_pkg.sv =====
// Shared constants, types and the glyph lookup for the integer-to-ASCII formatter.
// No dependencies; every other file of the block imports this package.
package itoa_pkg;

    // Width of the number to print.
    localparam int VALUE_BITS = 32;

    // Decimal digits needed for 2^VALUE_BITS - 1 (1233/4096 approximates log10(2)).
    localparam int DEC_DIGITS = ((VALUE_BITS * 1233) >> 12) + 1;
    localparam int HEX_DIGITS = (VALUE_BITS + 3) / 4;
    localparam int DIGIT_SLOTS = (DEC_DIGITS > HEX_DIGITS) ? DEC_DIGITS : HEX_DIGITS;
    localparam int BCD_W = DIGIT_SLOTS * 4;
    localparam int PTR_W = (DIGIT_SLOTS > 1) ? $clog2(DIGIT_SLOTS) : 1;
    localparam int CNT_W = $clog2(VALUE_BITS + 1);

    // Stream payload widths.
    localparam int IN_TDATA_W = ((VALUE_BITS + 7) / 8) * 8;
    localparam int FUNC_W = 2;
    localparam int CHAR_W = 8;

    // Format selector codes; bit 1 set selects hexadecimal.
    localparam logic [FUNC_W-1:0] FUNC_SDEC = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_UDEC = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_HEX  = 2'd2;

    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_UPA   = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_UPF   = 8'h46;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;       // capture an input item
        logic shift;      // one binary-to-BCD step
        logic set_ptr;    // point at the most significant nonzero digit
        logic put_sign;   // load '-' into the output register
        logic put_digit;  // load the pointed digit and step the pointer down
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic sign;       // a '-' precedes the digits
        logic ptr_zero;   // the pointer is at the least significant digit
    } t_dp_status;

    // Digit value to uppercase ASCII.
    function automatic logic [CHAR_W-1:0] glyph(input logic [3:0] d);
        logic [CHAR_W-1:0] ext;
        ext = {{(CHAR_W-4){1'b0}}, d};
        if (d < 4'd10) begin
            return CHAR_ZERO + ext;
        end else begin
            return CHAR_UPA - 8'd10 + ext;
        end
    endfunction

endpackage

// ===== hw/rtl/integer_to_ascii_formatter.sv =====
// Top level of the integer-to-ASCII formatter: joins controller and datapath.
// Depends on itoa_pkg, itoa_ctrl and itoa_datapath.
//
// Usage: the slave stream takes one number per item, the value in tdata and the
// format in tuser (0 signed decimal, 1 unsigned decimal, 2 or 3 uppercase hex).
// The master stream returns one ASCII character per item, most significant digit
// first, with tlast on the final character of the number. Negative signed values
// start with '-'. Zero prints a single '0'; there is no padding or prefix.
// Timing: one number is handled at a time. Decimal numbers pass through a
// shift-and-add-3 converter, one value bit per shift, and hex numbers skip it;
// the ST_PTR state then locates the leading digit, and one character leaves
// per cycle while the receiver takes them. A decimal number prints up to 11
// characters (a sign and 10 digits), a hex number up to 8.
// The next number is accepted as soon as the last character sits in the output
// register, even while that character still waits to be taken.
// When the receiver stalls, the output register holds its character and the
// block waits. A synchronous active-low reset empties the output and returns the
// block to idle, ready for a number.
module integer_to_ascii_formatter
    import itoa_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_TDATA_W-1:0] s_axis_tdata,   // [31:0] value
    input  logic [FUNC_W-1:0]     s_axis_tuser,   // [1:0] func
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [CHAR_W-1:0]     m_axis_tdata,   // [7:0] ascii_char
    output logic                  m_axis_tlast    // last_char
);

    t_dp_cmd    cmd;
    t_dp_status status;

    // Sequencing.
    itoa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_in_hex    (s_axis_tuser[1]),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_cmd       (cmd),
        .i_status    (status)
    );

    // Conversion and character output.
    itoa_datapath u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_value  (s_axis_tdata[VALUE_BITS-1:0]),
        .i_func   (s_axis_tuser),
        .o_status (status),
        .o_char   (m_axis_tdata),
        .o_last   (m_axis_tlast)
    );

endmodule

// ===== hw/rtl/itoa_ctrl.sv =====
// Controller of the integer-to-ASCII formatter: sequences load, conversion and
// character output, and owns the input ready and output valid. Uses itoa_pkg.
module itoa_ctrl
    import itoa_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic       i_in_hex,
    input  logic       i_out_ready,
    output logic       o_out_valid,
    output t_dp_cmd    o_cmd,
    input  t_dp_status i_status
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_PTR,
        ST_SIGN,
        ST_DIGIT
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_out_valid, n_out_valid;
    logic             out_free;
    logic             accept;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign accept      = i_in_valid && (r_state == ST_IDLE);
    // The output register can take a new character when empty or being drained.
    assign out_free    = !r_out_valid || i_out_ready;

    // Next state and datapath commands.
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = CNT_W'(VALUE_BITS);
                    n_state    = i_in_hex ? ST_PTR : ST_CONV;
                end
            end
            ST_CONV: begin
                o_cmd.shift = 1'b1;
                n_cnt       = r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    n_state = ST_PTR;
                end
            end
            ST_PTR: begin
                o_cmd.set_ptr = 1'b1;
                n_state       = i_status.sign ? ST_SIGN : ST_DIGIT;
            end
            ST_SIGN: begin
                if (out_free) begin
                    o_cmd.put_sign = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = ST_DIGIT;
                end
            end
            ST_DIGIT: begin
                if (out_free) begin
                    o_cmd.put_digit = 1'b1;
                    n_out_valid     = 1'b1;
                    if (i_status.ptr_zero) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State, step counter and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ===== hw/rtl/itoa_datapath.sv =====
// Datapath of the integer-to-ASCII formatter: magnitude, shift-and-add-3 BCD
// register, digit pointer and output character register. Uses itoa_pkg.
module itoa_datapath
    import itoa_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dp_cmd               i_cmd,
    input  logic [VALUE_BITS-1:0] i_value,
    input  logic [FUNC_W-1:0]     i_func,
    output t_dp_status            o_status,
    output logic [CHAR_W-1:0]     o_char,
    output logic                  o_last
);

    logic [VALUE_BITS-1:0] r_work;
    logic [BCD_W-1:0]      r_bcd;
    logic                  r_sign;
    logic [PTR_W-1:0]      r_ptr;
    logic [CHAR_W-1:0]     r_char;
    logic                  r_last;

    logic                  neg;
    logic [VALUE_BITS-1:0] mag;
    logic [BCD_W-1:0]      bcd_adj;
    logic [PTR_W-1:0]      msd;
    logic [3:0]            cur_digit;

    // Two's-complement magnitude in signed decimal mode.
    assign neg = (i_func == FUNC_SDEC) && i_value[VALUE_BITS-1];
    assign mag = neg ? VALUE_BITS'(~i_value + 1'b1) : i_value;

    // Add 3 to every BCD digit of 5 or more before the next shift.
    always_comb begin
        for (int j = 0; j < DIGIT_SLOTS; j++) begin
            if (r_bcd[4*j +: 4] >= 4'd5) begin
                bcd_adj[4*j +: 4] = r_bcd[4*j +: 4] + 4'd3;
            end else begin
                bcd_adj[4*j +: 4] = r_bcd[4*j +: 4];
            end
        end
    end

    // Highest nonzero digit; zero when the whole number is zero.
    always_comb begin
        msd = '0;
        for (int i = 0; i < DIGIT_SLOTS; i++) begin
            if (r_bcd[4*i +: 4] != 4'd0) begin
                msd = PTR_W'(i);
            end
        end
    end

    assign cur_digit = r_bcd[4*r_ptr +: 4];

    // Conversion registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_work <= '0;
            r_sign <= 1'b0;
        end else if (i_cmd.load) begin
            r_work <= mag;
            r_sign <= neg;
        end else if (i_cmd.shift) begin
            r_work <= {r_work[VALUE_BITS-2:0], 1'b0};
        end
    end

    // Digit store: raw nibbles in hex mode, built up by shifting in decimal mode.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_bcd <= i_func[1] ? BCD_W'(i_value) : '0;
        end else if (i_cmd.shift) begin
            r_bcd <= {bcd_adj[BCD_W-2:0], r_work[VALUE_BITS-1]};
        end
    end

    // Digit pointer walks from the most significant digit down.
    always_ff @(posedge i_clk) begin
        if (i_cmd.set_ptr) begin
            r_ptr <= msd;
        end else if (i_cmd.put_digit && (r_ptr != '0)) begin
            r_ptr <= r_ptr - 1'b1;
        end
    end

    // Output character register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.put_sign) begin
            r_char <= CHAR_MINUS;
            r_last <= 1'b0;
        end else if (i_cmd.put_digit) begin
            r_char <= glyph(cur_digit);
            r_last <= (r_ptr == '0);
        end
    end

    assign o_status.sign     = r_sign;
    assign o_status.ptr_zero = (r_ptr == '0);
    assign o_char            = r_char;
    assign o_last            = r_last;

endmodule

// ===== hw/rtl/itoa_checker.sv =====
// Port-level checks for the integer-to-ASCII formatter, bound to the top level.
// Depends on itoa_pkg.
module itoa_checker
    import itoa_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [CHAR_W-1:0]     m_axis_tdata,
    input logic                  m_axis_tlast
);

    // A number is in work right after it is taken, so no second item follows at once.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken in the cycle after an accepted item");

    // A stalled character and its last flag hold.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output item changed while stalled");

    // Only '-', decimal digits and uppercase hex letters come out.
    a_legal_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |->
            (m_axis_tdata == CHAR_MINUS) ||
            ((m_axis_tdata >= CHAR_ZERO) && (m_axis_tdata <= CHAR_NINE)) ||
            ((m_axis_tdata >= CHAR_UPA) && (m_axis_tdata <= CHAR_UPF)))
        else $error("illegal output character");

    // The sign is always followed by digits.
    a_sign_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata == CHAR_MINUS) |-> !m_axis_tlast)
        else $error("minus sign marked as last character");

endmodule

bind integer_to_ascii_formatter itoa_checker u_itoa_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
